// ===== rtl/ece_pkg.sv =====
// Shared types, constants and helper functions of the easing curve evaluator.
// Depends on nothing; every other file imports this package.
`default_nettype none

package ece_pkg;

    // Item field widths and fixed-point formats
    localparam int FRAC_BITS = 16;
    localparam int MODE_W    = 4;
    localparam int PROG_W    = FRAC_BITS + 1;
    localparam int OUT_W     = 18;
    localparam int PH_W      = 32;
    localparam int EXP_W     = 20;
    localparam int TAB_W     = 31;
    localparam int SIN_W     = 32;
    localparam int POW_W     = 31;
    localparam int BACK_W    = 26;

    localparam int SINE_DEPTH_DEF = 1024;
    localparam int EXP_DEPTH      = 256;

    localparam logic [PROG_W-1:0] ONE = PROG_W'(1 << FRAC_BITS);
    localparam logic [PH_W-1:0] QUARTER_TURN = 32'h4000_0000;

    localparam longint Q30         = 64'sd1 << 30;
    localparam longint PI_HALF_Q30 = 1686629713;
    localparam longint LN2_Q30     = 744261118;
    localparam longint BACK_C1 = (270158 * (64'sd1 << FRAC_BITS) + 50000) / 100000;
    localparam longint BACK_C2 = (170158 * (64'sd1 << FRAC_BITS) + 50000) / 100000;

    // Curve select codes
    localparam logic [MODE_W-1:0] MODE_SINE_IN     = 4'd0;
    localparam logic [MODE_W-1:0] MODE_SINE_OUT    = 4'd1;
    localparam logic [MODE_W-1:0] MODE_SINE_INOUT  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_BACK_IN     = 4'd3;
    localparam logic [MODE_W-1:0] MODE_BACK_OUT    = 4'd4;
    localparam logic [MODE_W-1:0] MODE_BACK_INOUT  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_ELAST_IN    = 4'd6;
    localparam logic [MODE_W-1:0] MODE_ELAST_OUT   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_ELAST_INOUT = 4'd8;
    localparam logic [MODE_W-1:0] MODE_BOUNCE_IN   = 4'd9;
    localparam logic [MODE_W-1:0] MODE_BOUNCE_OUT  = 4'd10;
    localparam logic [MODE_W-1:0] MODE_BOUNCE_INOUT = 4'd11;

    // Series denominators for the table builders
    localparam longint SIN_DEN [12] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600};
    localparam longint EXP_DEN [16] = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16};

    // Item tag that rides along the pipeline
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [PROG_W-1:0] prog;
    } t_tag;

    // Shift right by n, rounding half away from zero
    function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v, input int n);
        logic signed [63:0] h;
        h = 64'sd1 <<< (n - 1);
        if (v < 0) begin
            return (v + h - 64'sd1) >>> n;
        end
        return (v + h) >>> n;
    endfunction

    function automatic logic [TAB_W-1:0] clamp_q30(input longint v);
        if (v < 0) begin
            return '0;
        end
        if (v > Q30) begin
            return TAB_W'(Q30);
        end
        return TAB_W'(v);
    endfunction

    // Q30 sine of angle th (Q30 radians) by Taylor series
    function automatic logic [TAB_W-1:0] sin_entry(input longint th);
        longint th2;
        longint term;
        longint sum;
        th2  = (th * th) >>> 30;
        term = th;
        sum  = th;
        for (int k = 1; k <= 12; k++) begin
            term = ((term * th2) >>> 30) / SIN_DEN[k-1];
            sum  = (k % 2 == 1) ? sum - term : sum + term;
        end
        return clamp_q30(sum);
    endfunction

    // Q30 exp(-th) by Taylor series
    function automatic logic [TAB_W-1:0] exp_entry(input longint th);
        longint term;
        longint sum;
        term = Q30;
        sum  = Q30;
        for (int k = 1; k <= 16; k++) begin
            term = ((term * th) >>> 30) / EXP_DEN[k-1];
            sum  = (k % 2 == 1) ? sum - term : sum + term;
        end
        return clamp_q30(sum);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ece_front.sv =====
// Front stage: forms the sine phase and the power-of-two exponent of each item.
// Depends on ece_pkg.
`default_nettype none

module ece_front
    import ece_pkg::*;
(
    input  logic             i_clk,
    input  t_tag             i_tag,
    output logic [PH_W-1:0]  o_phase,
    output logic [EXP_W-1:0] o_exp
);

    localparam int NUM_W = 21;
    localparam int K_RCP = 24;
    localparam int PRD_W = NUM_W + 23;
    localparam int Q_W   = PRD_W - K_RCP;
    localparam int SH    = PH_W - FRAC_BITS;
    localparam logic [22:0] M3 = 23'(((1 << K_RCP) + 2) / 3);
    localparam logic [22:0] M9 = 23'(((1 << K_RCP) + 8) / 9);
    localparam logic [NUM_W-1:0] OFS6 = NUM_W'((5 << FRAC_BITS) / 4);
    localparam logic [NUM_W-1:0] OFS7 = NUM_W'((9 << FRAC_BITS) / 4);
    localparam logic [NUM_W-1:0] OFS8 = NUM_W'((19 << FRAC_BITS) / 8);
    localparam logic [EXP_W-1:0] TEN  = EXP_W'(10 << FRAC_BITS);

    logic [PROG_W-1:0] w_r;
    logic [PROG_W-1:0] w_omr;
    logic              w_lo;
    logic [NUM_W-1:0]  w_num;
    logic              w_div9;
    logic [PRD_W-1:0]  w_prd;
    logic [Q_W-1:0]    w_q;
    logic [23:0]       w_qd;
    logic [3:0]        w_rem;
    logic [16:0]       w_frac;
    logic [PH_W-1:0]   w_ph_div;
    logic [PH_W-1:0]   w_ph7;
    logic [PH_W-1:0]   n_phase;
    logic [EXP_W-1:0]  n_exp;
    logic [PH_W-1:0]   r_phase;
    logic [EXP_W-1:0]  r_exp;

    assign w_r   = i_tag.prog;
    assign w_omr = ONE - w_r;
    assign w_lo  = w_r < (ONE >> 1);

    // Elastic phase numerator and divisor
    always_comb begin
        w_div9 = 1'b0;
        case (i_tag.mode)
            MODE_ELAST_IN:  w_num = NUM_W'(w_r) * NUM_W'(10) + OFS6;
            MODE_ELAST_OUT: w_num = NUM_W'(w_r) * NUM_W'(10) + OFS7;
            default: begin
                w_num  = NUM_W'(w_r) * NUM_W'(20) + OFS8;
                w_div9 = 1'b1;
            end
        endcase
    end

    // Divide by 3 or 9 through a reciprocal, then restore the fraction
    assign w_prd = PRD_W'(w_num) * PRD_W'(w_div9 ? M9 : M3);
    assign w_q   = w_prd[PRD_W-1:K_RCP];
    assign w_qd  = w_div9 ? (24'(w_q) << 3) + 24'(w_q) : (24'(w_q) << 1) + 24'(w_q);
    assign w_rem = 4'(24'(w_num) - w_qd);

    always_comb begin
        if (w_div9) begin
            case (w_rem)
                4'd1:    w_frac = 17'((1 << (FRAC_BITS + 1)) / 9);
                4'd2:    w_frac = 17'((2 << (FRAC_BITS + 1)) / 9);
                4'd3:    w_frac = 17'((3 << (FRAC_BITS + 1)) / 9);
                4'd4:    w_frac = 17'((4 << (FRAC_BITS + 1)) / 9);
                4'd5:    w_frac = 17'((5 << (FRAC_BITS + 1)) / 9);
                4'd6:    w_frac = 17'((6 << (FRAC_BITS + 1)) / 9);
                4'd7:    w_frac = 17'((7 << (FRAC_BITS + 1)) / 9);
                4'd8:    w_frac = 17'((8 << (FRAC_BITS + 1)) / 9);
                default: w_frac = '0;
            endcase
            w_ph_div = PH_W'({w_q, {(FRAC_BITS + 1){1'b0}}} + (Q_W + FRAC_BITS + 1)'(w_frac));
        end else begin
            case (w_rem)
                4'd1:    w_frac = 17'((1 << FRAC_BITS) / 3);
                4'd2:    w_frac = 17'((2 << FRAC_BITS) / 3);
                default: w_frac = '0;
            endcase
            w_ph_div = PH_W'({w_q, {FRAC_BITS{1'b0}}} + (Q_W + FRAC_BITS)'(w_frac));
        end
    end

    assign w_ph7 = PH_W'(w_r) * PH_W'(7);

    // Phase and exponent per curve
    always_comb begin
        n_phase = '0;
        n_exp   = '0;
        unique case (i_tag.mode)
            MODE_SINE_IN:    n_phase = (PH_W'(w_r) << (SH - 2)) + QUARTER_TURN;
            MODE_SINE_OUT:   n_phase = PH_W'(w_r) << (SH - 2);
            MODE_SINE_INOUT: n_phase = (PH_W'(w_r) << (SH - 1)) + QUARTER_TURN;
            MODE_ELAST_IN: begin
                n_phase = w_ph_div;
                n_exp   = EXP_W'(w_omr) * EXP_W'(10);
            end
            MODE_ELAST_OUT: begin
                n_phase = w_ph_div;
                n_exp   = EXP_W'(w_r) * EXP_W'(10);
            end
            MODE_ELAST_INOUT: begin
                n_phase = w_ph_div;
                n_exp   = w_lo ? TEN - EXP_W'(w_r) * EXP_W'(20)
                               : EXP_W'(w_r) * EXP_W'(20) - TEN;
            end
            MODE_BOUNCE_IN: begin
                n_phase = w_ph7 << (SH - 2);
                n_exp   = EXP_W'(w_omr) * EXP_W'(6);
            end
            MODE_BOUNCE_OUT: begin
                n_phase = (w_ph7 << (SH - 2)) + QUARTER_TURN;
                n_exp   = EXP_W'(w_r) * EXP_W'(6);
            end
            MODE_BOUNCE_INOUT: begin
                n_phase = w_ph7 << (SH - 1);
                n_exp   = w_lo ? EXP_W'(w_omr) << 3 : EXP_W'(w_r) << 3;
            end
            default: begin
                n_phase = '0;
                n_exp   = '0;
            end
        endcase
    end

    // Advance one stage
    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_exp   <= n_exp;
    end

    assign o_phase = r_phase;
    assign o_exp   = r_exp;

endmodule

`default_nettype wire

// ===== rtl/ece_sine.sv =====
// Sine unit: quarter-wave ROM with linear interpolation, three register stages.
// Depends on ece_pkg.
`default_nettype none

module ece_sine
    import ece_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic [PH_W-1:0]         i_phase,
    output logic signed [SIN_W-1:0] o_sin
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PW = 30 + AW;

    logic [TAB_W-1:0] w_rom [SINE_TABLE_DEPTH + 1];

    // Quarter-wave table, Q30
    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
        localparam longint TH = (PI_HALF_Q30 * g) / SINE_TABLE_DEPTH;
        assign w_rom[g] = sin_entry(TH);
    end

    logic [1:0]               w_quad;
    logic [30:0]              w_x;
    logic [PW-1:0]            w_pos;
    logic [AW-1:0]            w_ia;
    logic [AW-1:0]            w_ib;
    logic [TAB_W-1:0]         r_lo;
    logic [TAB_W-1:0]         r_hi;
    logic [29:0]              r_f;
    logic                     r_neg;
    logic signed [31:0]       w_diff;
    logic signed [62:0]       r_prod;
    logic [TAB_W-1:0]         r_lo2;
    logic                     r_neg2;
    logic signed [63:0]       w_rnd;
    logic signed [SIN_W-1:0]  w_mag;
    logic signed [SIN_W-1:0]  r_sin;

    // Fold the angle into the first quadrant
    assign w_quad = i_phase[31:30];
    assign w_x    = w_quad[0] ? 31'(Q30) - {1'b0, i_phase[29:0]} : {1'b0, i_phase[29:0]};
    assign w_pos  = PW'(w_x) * PW'(SINE_TABLE_DEPTH);
    assign w_ia   = w_pos[PW-1:30];
    assign w_ib   = (w_ia == AW'(SINE_TABLE_DEPTH)) ? w_ia : w_ia + AW'(1);

    // Read both neighbors
    always_ff @(posedge i_clk) begin
        r_lo  <= w_rom[w_ia];
        r_hi  <= w_rom[w_ib];
        r_f   <= w_pos[29:0];
        r_neg <= w_quad[1];
    end

    // Scale the step by the fraction
    assign w_diff = $signed({1'b0, r_hi}) - $signed({1'b0, r_lo});

    always_ff @(posedge i_clk) begin
        r_prod <= w_diff * $signed({1'b0, r_f});
        r_lo2  <= r_lo;
        r_neg2 <= r_neg;
    end

    // Add the rounded step and apply the sign
    assign w_rnd = rnd_sh(64'(r_prod), 30);
    assign w_mag = $signed({1'b0, r_lo2}) + SIN_W'(w_rnd);

    always_ff @(posedge i_clk) begin
        r_sin <= r_neg2 ? -w_mag : w_mag;
    end

    assign o_sin = r_sin;

endmodule

`default_nettype wire

// ===== rtl/ece_pow2.sv =====
// Power-of-two unit: 2^-e from an interpolated ROM and a right shift, three stages.
// Depends on ece_pkg.
`default_nettype none

module ece_pow2
    import ece_pkg::*;
(
    input  logic             i_clk,
    input  logic [EXP_W-1:0] i_exp,
    output logic [POW_W-1:0] o_pow
);

    localparam int IB = $clog2(EXP_DEPTH);
    localparam int AW = $clog2(EXP_DEPTH + 1);
    localparam int NW = EXP_W - FRAC_BITS;

    logic [TAB_W-1:0] w_rom [EXP_DEPTH + 1];

    // Table of 2^(-j/EXP_DEPTH), Q30
    for (genvar g = 0; g <= EXP_DEPTH; g++) begin : g_rom
        localparam longint TH = (LN2_Q30 * g) / EXP_DEPTH;
        assign w_rom[g] = exp_entry(TH);
    end

    logic [AW-1:0]         w_ia;
    logic [AW-1:0]         w_ib;
    logic [FRAC_BITS-1:0]  w_f;
    logic [TAB_W-1:0]      r_lo;
    logic [TAB_W-1:0]      r_hi;
    logic [FRAC_BITS-1:0]  r_f;
    logic [NW-1:0]         r_n;
    logic signed [31:0]    w_diff;
    logic signed [48:0]    r_prod;
    logic [TAB_W-1:0]      r_lo2;
    logic [NW-1:0]         r_n2;
    logic signed [63:0]    w_rnd;
    logic signed [31:0]    w_v;
    logic [POW_W-1:0]      r_pow;

    // Split the fraction into table index and interpolation weight
    assign w_ia = AW'(i_exp[FRAC_BITS-1 -: IB]);
    assign w_ib = w_ia + AW'(1);
    assign w_f  = {i_exp[FRAC_BITS-IB-1:0], {IB{1'b0}}};

    always_ff @(posedge i_clk) begin
        r_lo <= w_rom[w_ia];
        r_hi <= w_rom[w_ib];
        r_f  <= w_f;
        r_n  <= i_exp[EXP_W-1:FRAC_BITS];
    end

    assign w_diff = $signed({1'b0, r_hi}) - $signed({1'b0, r_lo});

    always_ff @(posedge i_clk) begin
        r_prod <= w_diff * $signed({1'b0, r_f});
        r_lo2  <= r_lo;
        r_n2   <= r_n;
    end

    // Interpolate, then shift by the integer part
    assign w_rnd = rnd_sh(64'(r_prod), FRAC_BITS);
    assign w_v   = $signed({1'b0, r_lo2}) + 32'(w_rnd);

    always_ff @(posedge i_clk) begin
        r_pow <= (w_v < 0) ? '0 : POW_W'(w_v) >> r_n2;
    end

    assign o_pow = r_pow;

endmodule

`default_nettype wire

// ===== rtl/ece_back.sv =====
// Back curves: cubic overshoot polynomial over four register stages.
// Depends on ece_pkg.
`default_nettype none

module ece_back
    import ece_pkg::*;
(
    input  logic                     i_clk,
    input  t_tag                     i_tag,
    output logic signed [BACK_W-1:0] o_back
);

    localparam logic signed [19:0] C1   = 20'(BACK_C1);
    localparam logic signed [21:0] C2   = 22'(BACK_C2);
    localparam logic signed [20:0] HALF = 21'((5 << FRAC_BITS) / 2);
    localparam logic signed [17:0] ONE_S = 18'(ONE);

    logic signed [17:0]       w_rs;
    logic                     w_lo;
    logic                     w_sel_r;
    logic signed [17:0]       w_x;
    logic signed [20:0]       w_x7;
    logic signed [35:0]       r_xx;
    logic signed [37:0]       r_cx;
    logic signed [20:0]       r_b5;
    logic [MODE_W-1:0]        r_mode1;
    logic                     r_lo1;
    logic signed [21:0]       w_cr;
    logic signed [21:0]       n_b;
    logic signed [17:0]       r_a;
    logic signed [21:0]       r_b;
    logic [MODE_W-1:0]        r_mode2;
    logic                     r_lo2;
    logic signed [39:0]       r_ab;
    logic [MODE_W-1:0]        r_mode3;
    logic                     r_lo3;
    logic signed [23:0]       w_w;
    logic signed [BACK_W-1:0] n_v;
    logic signed [BACK_W-1:0] r_v;

    // Pick r or r - 1 and form the squares and scaled terms
    assign w_rs    = $signed({1'b0, i_tag.prog});
    assign w_lo    = i_tag.prog < (ONE >> 1);
    assign w_sel_r = (i_tag.mode == MODE_BACK_IN) || ((i_tag.mode == MODE_BACK_INOUT) && w_lo);
    assign w_x     = w_sel_r ? w_rs : w_rs - ONE_S;
    assign w_x7    = 21'(w_x) * 21'sd7;

    always_ff @(posedge i_clk) begin
        r_xx    <= w_x * w_x;
        r_cx    <= w_x * C1;
        r_b5    <= w_lo ? w_x7 - HALF : w_x7 + HALF;
        r_mode1 <= i_tag.mode;
        r_lo1   <= w_lo;
    end

    // Round the products and build the linear factor
    assign w_cr = 22'(rnd_sh(64'(r_cx), FRAC_BITS));

    always_comb begin
        case (r_mode1)
            MODE_BACK_IN:  n_b = w_cr - C2;
            MODE_BACK_OUT: n_b = w_cr + C2;
            default:       n_b = 22'(r_b5);
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_a     <= 18'(rnd_sh(64'(r_xx), FRAC_BITS));
        r_b     <= n_b;
        r_mode2 <= r_mode1;
        r_lo2   <= r_lo1;
    end

    always_ff @(posedge i_clk) begin
        r_ab    <= r_a * r_b;
        r_mode3 <= r_mode2;
        r_lo3   <= r_lo2;
    end

    // Final rounding and offset
    assign w_w = 24'(rnd_sh(64'(r_ab), FRAC_BITS));

    always_comb begin
        case (r_mode3)
            MODE_BACK_IN:  n_v = BACK_W'(w_w);
            MODE_BACK_OUT: n_v = BACK_W'(ONE_S) + BACK_W'(w_w);
            default: begin
                n_v = r_lo3 ? BACK_W'(w_w) <<< 1 : BACK_W'(ONE_S) + (BACK_W'(w_w) <<< 1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
    end

    assign o_back = r_v;

endmodule

`default_nettype wire

// ===== rtl/easing_curve_evaluator.sv =====
// Top level of the easing curve evaluator: input stage, curve units, final combine.
// Depends on ece_pkg, ece_front, ece_sine, ece_pow2 and ece_back.
//
//  channel   signals                          direction  transfer
//  command   start, busy, i_mode, i_progress  in         start && !busy
//  result    o_valid, o_eased_value           out        o_valid, one cycle
//
// One item is taken every cycle; busy stays low.
// Each result passes through the input register, the phase stage, three
// ROM/interpolation stages, the exponent-times-sine multiply and the output register.
// Synchronous reset clears the valid pipeline; results are never held back.
`default_nettype none

module easing_curve_evaluator
    import ece_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [MODE_W-1:0]       i_mode,
    input  logic [PROG_W-1:0]       i_progress,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_eased_value
);

    localparam int V_W = 40;
    localparam logic signed [V_W-1:0] ONE_V   = V_W'(ONE);
    localparam logic signed [V_W-1:0] OUT_MAX = V_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [V_W-1:0] OUT_MIN = -V_W'(1 << (OUT_W - 1));

    logic                     w_accept;
    logic [7:1]               r_vld;
    t_tag                     r_tag [1:6];
    logic [PH_W-1:0]          w_phase;
    logic [EXP_W-1:0]         w_exp;
    logic signed [SIN_W-1:0]  w_sin;
    logic [POW_W-1:0]         w_pow;
    logic signed [BACK_W-1:0] w_back;
    logic                     w_bounce;
    logic signed [SIN_W-1:0]  w_sop;
    logic signed [63:0]       r_prod;
    logic signed [SIN_W-1:0]  r_sin6;
    logic signed [BACK_W-1:0] r_back6;
    logic [PROG_W-1:0]        w_r6;
    logic                     w_lo6;
    logic                     w_end6;
    logic signed [V_W-1:0]    w_s14;
    logic signed [V_W-1:0]    w_m2;
    logic signed [V_W-1:0]    w_p60;
    logic signed [V_W-1:0]    w_p61;
    logic signed [V_W-1:0]    w_p57;
    logic signed [V_W-1:0]    n_v;
    logic signed [OUT_W-1:0]  r_out;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[6:1], w_accept};
        end
    end

    // Capture the beat with progress saturated at one; advance the tag
    always_ff @(posedge i_clk) begin
        r_tag[1].mode <= i_mode;
        r_tag[1].prog <= (i_progress > ONE) ? ONE : i_progress;
        for (int k = 2; k <= 6; k++) begin
            r_tag[k] <= r_tag[k-1];
        end
    end

    ece_front u_front (
        .i_clk   (i_clk),
        .i_tag   (r_tag[1]),
        .o_phase (w_phase),
        .o_exp   (w_exp)
    );

    ece_sine #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine (
        .i_clk   (i_clk),
        .i_phase (w_phase),
        .o_sin   (w_sin)
    );

    ece_pow2 u_pow2 (
        .i_clk (i_clk),
        .i_exp (w_exp),
        .o_pow (w_pow)
    );

    ece_back u_back (
        .i_clk  (i_clk),
        .i_tag  (r_tag[1]),
        .o_back (w_back)
    );

    // Exponent times sine; bounce curves take the magnitude of the sine
    assign w_bounce = (r_tag[5].mode == MODE_BOUNCE_IN) || (r_tag[5].mode == MODE_BOUNCE_OUT)
                   || (r_tag[5].mode == MODE_BOUNCE_INOUT);
    assign w_sop    = (w_bounce && w_sin < 0) ? -w_sin : w_sin;

    always_ff @(posedge i_clk) begin
        r_prod  <= $signed({1'b0, w_pow}) * w_sop;
        r_sin6  <= w_sin;
        r_back6 <= w_back;
    end

    // Round and combine per curve
    assign w_r6  = r_tag[6].prog;
    assign w_lo6 = w_r6 < (ONE >> 1);
    assign w_end6 = (w_r6 == '0) || (w_r6 == ONE);
    assign w_s14 = V_W'(rnd_sh(64'(r_sin6), 30 - FRAC_BITS));
    assign w_m2  = V_W'(rnd_sh(Q30 - 64'(r_sin6), 31 - FRAC_BITS));
    assign w_p60 = V_W'(rnd_sh(r_prod, 60 - FRAC_BITS));
    assign w_p61 = V_W'(rnd_sh(r_prod, 61 - FRAC_BITS));
    assign w_p57 = V_W'(rnd_sh(r_prod, 57 - FRAC_BITS));

    always_comb begin
        unique case (r_tag[6].mode)
            MODE_SINE_IN:      n_v = ONE_V - w_s14;
            MODE_SINE_OUT:     n_v = w_s14;
            MODE_SINE_INOUT:   n_v = w_m2;
            MODE_BACK_IN, MODE_BACK_OUT, MODE_BACK_INOUT: begin
                n_v = V_W'(r_back6);
            end
            MODE_ELAST_IN:     n_v = w_end6 ? V_W'(w_r6) : -w_p60;
            MODE_ELAST_OUT:    n_v = w_end6 ? V_W'(w_r6) : ONE_V + w_p60;
            MODE_ELAST_INOUT: begin
                if (w_end6) begin
                    n_v = V_W'(w_r6);
                end else begin
                    n_v = w_lo6 ? -w_p61 : ONE_V + w_p61;
                end
            end
            MODE_BOUNCE_IN:    n_v = w_p60;
            MODE_BOUNCE_OUT:   n_v = ONE_V - w_p60;
            MODE_BOUNCE_INOUT: n_v = w_lo6 ? w_p57 : ONE_V - w_p57;
            default:           n_v = V_W'(w_r6);
        endcase
    end

    // Saturate into the result register
    always_ff @(posedge i_clk) begin
        if (n_v > OUT_MAX) begin
            r_out <= OUT_W'(OUT_MAX);
        end else if (n_v < OUT_MIN) begin
            r_out <= OUT_W'(OUT_MIN);
        end else begin
            r_out <= OUT_W'(n_v);
        end
    end

    assign o_valid       = r_vld[7];
    assign o_eased_value = r_out;

    // Every command beat yields one result at the pipeline output
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##7 o_valid)
        else $error("result missing after command beat");

    // No result without an earlier command beat
    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, 7))
        else $error("result without command beat");

    // Elastic curves start exactly at zero
    a_elast0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[6] && r_tag[6].prog == '0 && (r_tag[6].mode == MODE_ELAST_IN
            || r_tag[6].mode == MODE_ELAST_OUT || r_tag[6].mode == MODE_ELAST_INOUT))
        |=> (o_eased_value == '0))
        else $error("elastic curve not zero at start");

endmodule

`default_nettype wire

// ===== tb/sv/easing_curve_evaluator_checker.sv =====
// Scoreboard of the easing curve evaluator: predicts each eased value and checks results.
// Depends on ece_pkg for widths, fixed-point constants and the curve select codes.
`default_nettype none

module easing_curve_evaluator_checker
    import ece_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [MODE_W-1:0]       i_mode,
    input  logic [PROG_W-1:0]       i_progress,
    input  logic                    o_valid,
    input  logic signed [OUT_W-1:0] o_eased_value,
    output int                      o_errors,
    output int                      o_pending
);

    localparam int     SIN_DEPTH = 1024;
    localparam longint ONE_L     = 64'sd1 << FRAC_BITS;

    longint sine_lut [SIN_DEPTH+1];
    longint exp_lut  [EXP_DEPTH+1];
    logic signed [OUT_W-1:0] eased_q [$];
    int mismatches;

    // Build the quarter-wave sine and 2^(-j/256) tables by integer series
    initial begin
        longint th, th2, term, sum;
        for (int i = 0; i <= SIN_DEPTH; i++) begin
            th   = PI_HALF_Q30 * i / SIN_DEPTH;
            th2  = (th * th) >>> 30;
            term = th;
            sum  = th;
            for (int k = 1; k <= 12; k++) begin
                term = ((term * th2) >>> 30) / ((2 * k) * (2 * k + 1));
                sum  = (k % 2 == 1) ? sum - term : sum + term;
            end
            sine_lut[i] = (sum < 0) ? 0 : (sum > Q30) ? Q30 : sum;
        end
        for (int i = 0; i <= EXP_DEPTH; i++) begin
            th   = LN2_Q30 * i / EXP_DEPTH;
            term = Q30;
            sum  = Q30;
            for (int k = 1; k <= 16; k++) begin
                term = ((term * th) >>> 30) / k;
                sum  = (k % 2 == 1) ? sum - term : sum + term;
            end
            exp_lut[i] = (sum < 0) ? 0 : (sum > Q30) ? Q30 : sum;
        end
    end

    function automatic longint round_shift(input longint v, input int n);
        longint h;
        if (n == 0) begin
            return v;
        end
        h = 64'sd1 << (n - 1);
        if (v >= 0) begin
            return (v + h) >>> n;
        end
        return -((-v + h) >>> n);
    endfunction

    function automatic longint sine_of_turn(input logic [31:0] ph);
        longint x, pos, idx, f, mag;
        x = longint'(ph[29:0]);
        if (ph[30]) begin
            x = Q30 - x;
        end
        pos = x * SIN_DEPTH;
        idx = pos >>> 30;
        f   = pos & (Q30 - 1);
        if (idx >= SIN_DEPTH) begin
            mag = sine_lut[SIN_DEPTH];
        end else begin
            mag = sine_lut[idx] + round_shift((sine_lut[idx+1] - sine_lut[idx]) * f, 30);
        end
        return ph[31] ? -mag : mag;
    endfunction

    function automatic longint pow2_neg(input longint e);
        longint n, pos, idx, f, v;
        n   = e >>> FRAC_BITS;
        pos = (e & (ONE_L - 1)) * EXP_DEPTH;
        idx = pos >>> FRAC_BITS;
        f   = pos & (ONE_L - 1);
        if (idx >= EXP_DEPTH) begin
            idx = EXP_DEPTH - 1;
        end
        v = exp_lut[idx] + round_shift((exp_lut[idx+1] - exp_lut[idx]) * f, FRAC_BITS);
        if (n >= 31 || v < 0) begin
            return 0;
        end
        return v >>> n;
    endfunction

    function automatic logic [31:0] turn_phase(input longint num, input longint mul,
                                               input longint div);
        longint p;
        p = ((num * mul) << (32 - FRAC_BITS)) / div;
        return p[31:0];
    endfunction

    function automatic longint mul_frac(input longint a, input longint b);
        return round_shift(a * b, FRAC_BITS);
    endfunction

    // Evaluate one curve at saturated progress, then clamp to the output range
    function automatic logic signed [OUT_W-1:0] eased_of(input logic [MODE_W-1:0] mode,
                                                         input logic [PROG_W-1:0] prog);
        longint r, v, t, s;
        logic [31:0] ph;
        r = longint'(prog);
        if (r > ONE_L) begin
            r = ONE_L;
        end
        case (mode)
            MODE_SINE_IN: begin
                ph = turn_phase(r, 1, 4) + QUARTER_TURN;
                v  = ONE_L - round_shift(sine_of_turn(ph), 30 - FRAC_BITS);
            end
            MODE_SINE_OUT: begin
                v = round_shift(sine_of_turn(turn_phase(r, 1, 4)), 30 - FRAC_BITS);
            end
            MODE_SINE_INOUT: begin
                ph = turn_phase(r, 1, 2) + QUARTER_TURN;
                v  = round_shift(Q30 - sine_of_turn(ph), 31 - FRAC_BITS);
            end
            MODE_BACK_IN: begin
                v = mul_frac(mul_frac(r, r), mul_frac(BACK_C1, r) - BACK_C2);
            end
            MODE_BACK_OUT: begin
                t = r - ONE_L;
                v = ONE_L + mul_frac(mul_frac(t, t), mul_frac(BACK_C1, t) + BACK_C2);
            end
            MODE_BACK_INOUT: begin
                if (r < ONE_L / 2) begin
                    v = 2 * mul_frac(mul_frac(r, r), 7 * r - 5 * ONE_L / 2);
                end else begin
                    t = r - ONE_L;
                    v = ONE_L + 2 * mul_frac(mul_frac(t, t), 7 * t + 5 * ONE_L / 2);
                end
            end
            MODE_ELAST_IN: begin
                if (r == 0 || r == ONE_L) begin
                    v = r;
                end else begin
                    s = sine_of_turn(turn_phase(10 * r + 5 * ONE_L / 4, 1, 3));
                    v = -round_shift(pow2_neg(10 * (ONE_L - r)) * s, 60 - FRAC_BITS);
                end
            end
            MODE_ELAST_OUT: begin
                if (r == 0 || r == ONE_L) begin
                    v = r;
                end else begin
                    s = sine_of_turn(turn_phase(10 * r + 9 * ONE_L / 4, 1, 3));
                    v = ONE_L + round_shift(pow2_neg(10 * r) * s, 60 - FRAC_BITS);
                end
            end
            MODE_ELAST_INOUT: begin
                if (r == 0 || r == ONE_L) begin
                    v = r;
                end else begin
                    s = sine_of_turn(turn_phase(20 * r + 19 * ONE_L / 8, 2, 9));
                    if (r < ONE_L / 2) begin
                        v = -round_shift(pow2_neg(10 * ONE_L - 20 * r) * s, 61 - FRAC_BITS);
                    end else begin
                        v = ONE_L + round_shift(pow2_neg(20 * r - 10 * ONE_L) * s,
                                                61 - FRAC_BITS);
                    end
                end
            end
            MODE_BOUNCE_IN: begin
                s = sine_of_turn(turn_phase(r, 7, 4));
                s = (s < 0) ? -s : s;
                v = round_shift(pow2_neg(6 * (ONE_L - r)) * s, 60 - FRAC_BITS);
            end
            MODE_BOUNCE_OUT: begin
                ph = turn_phase(r, 7, 4) + QUARTER_TURN;
                s  = sine_of_turn(ph);
                s  = (s < 0) ? -s : s;
                v  = ONE_L - round_shift(pow2_neg(6 * r) * s, 60 - FRAC_BITS);
            end
            MODE_BOUNCE_INOUT: begin
                s = sine_of_turn(turn_phase(r, 7, 2));
                s = (s < 0) ? -s : s;
                if (r < ONE_L / 2) begin
                    v = round_shift(pow2_neg(8 * (ONE_L - r)) * s, 57 - FRAC_BITS);
                end else begin
                    v = ONE_L - round_shift(pow2_neg(8 * r) * s, 57 - FRAC_BITS);
                end
            end
            default: begin
                v = r;
            end
        endcase
        if (v > 131071) begin
            v = 131071;
        end
        if (v < -131072) begin
            v = -131072;
        end
        return v[OUT_W-1:0];
    endfunction

    assign o_errors  = mismatches;
    assign o_pending = eased_q.size();

    // Queue a prediction on each command beat, check each result beat
    always @(posedge i_clk) begin
        logic signed [OUT_W-1:0] want;
        if (!i_rst_n) begin
            eased_q.delete();
            mismatches <= 0;
        end else begin
            if (o_valid) begin
                if (eased_q.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result %0d", o_eased_value);
                    end
                    mismatches <= mismatches + 1;
                end else begin
                    want = eased_q.pop_front();
                    if (want !== o_eased_value) begin
                        if (mismatches < 10) begin
                            $display("eased_value mismatch: expected %0d actual %0d",
                                     want, o_eased_value);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (start && !busy) begin
                eased_q.push_back(eased_of(i_mode, i_progress));
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/easing_curve_evaluator_test.sv =====
// Top of the easing curve evaluator test: clock, reset, command stimulus and verdict.
// Depends on ece_pkg, easing_curve_evaluator and easing_curve_evaluator_checker.
`default_nettype none

module easing_curve_evaluator_test;
    import ece_pkg::*;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [MODE_W-1:0]       i_mode;
    logic [PROG_W-1:0]       i_progress;
    logic                    o_valid;
    logic signed [OUT_W-1:0] o_eased_value;
    logic                    busy_mid;
    int                      errors;
    int                      pending;
    int                      idle_pct;

    easing_curve_evaluator DUT (.*);

    easing_curve_evaluator_checker scoreboard (
        .i_clk, .i_rst_n, .start, .busy, .i_mode, .i_progress,
        .o_valid, .o_eased_value, .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Sample busy mid-cycle; it is the value seen at the next rising edge
    always @(negedge i_clk) begin
        busy_mid <= busy;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // Present one command beat and hold it until accepted; idle cycle by cycle at random
    task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [PROG_W-1:0] prog);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_mode     <= mode;
        i_progress <= prog;
        do @(posedge i_clk); while (busy_mid);
    endtask

    function automatic logic [PROG_W-1:0] random_progress();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6) begin
            return PROG_W'($urandom_range(65536));
        end else if (pick < 8) begin
            return PROG_W'($urandom);
        end else if (pick == 8) begin
            return PROG_W'($urandom_range(65536, 65530));
        end
        return PROG_W'($urandom_range(6));
    endfunction

    initial begin
        start      = 1'b0;
        i_mode     = '0;
        i_progress = '0;
        i_rst_n    = 1'b0;
        idle_pct   = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every mode at zero, elastic endpoints, saturation, midpoints
        for (int m = 0; m < 16; m++) begin
            send_beat(MODE_W'(m), '0);
        end
        send_beat(MODE_ELAST_IN, ONE);
        send_beat(MODE_ELAST_OUT, ONE);
        send_beat(MODE_ELAST_INOUT, ONE);
        send_beat(MODE_ELAST_OUT, ONE + 1);
        send_beat(MODE_SINE_IN, '1);
        send_beat(4'd15, '1);
        send_beat(MODE_BACK_INOUT, ONE >> 1);
        send_beat(MODE_ELAST_INOUT, ONE >> 1);
        send_beat(MODE_BOUNCE_INOUT, ONE >> 1);

        // Random: three pacing phases
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 28 : (ph == 1) ? 69 : 0;
            for (int n = 0; n < 467; n++) begin
                send_beat(MODE_W'($urandom_range(15)), random_progress());
            end
        end
        start <= 1'b0;

        // Drain outstanding results, then allow the pipeline to settle
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
